### hdl/pbbf_pkg.sv
// ============================================================================
// pbbf_pkg
// Shared types and constants for the pixel bounding box finder.
// ============================================================================
`default_nettype none

package pbbf_pkg;

  // largest frame dimension and derived widths
  localparam int MAX_DIM = 4096;
  localparam int POS_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = POS_W + 1;

  // fixed port widths
  localparam int PIXEL_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 13;

  // match mode codes
  typedef enum logic [1:0] {
    MODE_ALPHA_NONZERO = 2'd0,
    MODE_ANY_NONZERO   = 2'd1,
    MODE_DIFFERS       = 2'd2,
    MODE_UNUSED        = 2'd3
  } match_mode_t;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATCH_MODE   = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2,
    REG_NONE         = 2'd3
  } reg_index_t;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(MAX_DIM);

  // clamp a configured size into 1..MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > CFG_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/pixel_bounding_box_finder.sv
// ============================================================================
// pixel_bounding_box_finder
// Bounding rectangle of qualifying pixels over one raster-order frame.
// ============================================================================
// Takes one ARGB pixel word per cycle together with its base-frame pixel and
// tracks the smallest and largest column and row of pixels that qualify under
// match_mode (alpha nonzero, any byte nonzero, or differs from base). Each
// word is folded into the running bounds in the cycle it is accepted, so the
// sustained rate is one word per clock; the single result register is the
// only thing that can stall the input, and only on a frame's last pixel while
// the previous rectangle has not yet been taken. The rectangle appears in the
// cycle after the last pixel of the frame is accepted; found=0 with all-zero
// fields means no pixel qualified. Sizes of 0 act as 1 and sizes above 4096
// act as 4096. Write configuration only while the block is idle.
`default_nettype none

module pixel_bounding_box_finder (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_write,
  input  wire logic [pbbf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pbbf_pkg::CFG_W-1:0]     cfg_data,
  // pixel input
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [pbbf_pkg::PIXEL_W-1:0]   pixel_word,
  input  wire logic [pbbf_pkg::PIXEL_W-1:0]   base_pixel,
  // rectangle output
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               found,
  output logic [pbbf_pkg::POS_W-1:0]          rect_left,
  output logic [pbbf_pkg::POS_W-1:0]          rect_top,
  output logic [pbbf_pkg::DIM_W-1:0]          rect_width,
  output logic [pbbf_pkg::DIM_W-1:0]          rect_height
);

  import pbbf_pkg::*;

  // configuration registers
  match_mode_t      match_mode;
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  // frame tracking state
  logic [POS_W-1:0] column_position;
  logic [POS_W-1:0] row_position;
  logic [POS_W-1:0] min_column;
  logic [POS_W-1:0] max_column;
  logic [POS_W-1:0] min_row;
  logic [POS_W-1:0] max_row;
  logic             any_hit;

  logic [POS_W-1:0] min_column_next;
  logic [POS_W-1:0] max_column_next;
  logic [POS_W-1:0] min_row_next;
  logic [POS_W-1:0] max_row_next;

  logic [DIM_W-1:0] width_eff;
  logic [DIM_W-1:0] height_eff;
  logic             row_end;
  logic             frame_end;
  logic             qualify;
  logic             same_color;
  logic             accept;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      match_mode   <= MODE_ALPHA_NONZERO;
      frame_width  <= DIM_RESET;
      frame_height <= DIM_RESET;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_MATCH_MODE:   match_mode   <= match_mode_t'(cfg_data[1:0]);
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective sizes and end of row / frame
  assign width_eff  = eff_dim(frame_width);
  assign height_eff = eff_dim(frame_height);
  assign row_end    = !((DIM_W'(column_position) + DIM_W'(1)) < width_eff);
  assign frame_end  = row_end && !((DIM_W'(row_position) + DIM_W'(1)) < height_eff);

  // pixel comparison against the base frame
  always_comb begin
    same_color = 1'b0;
    if (pixel_word[31:24] == base_pixel[31:24]) begin
      same_color = (pixel_word[31:24] == 8'd0) || (pixel_word[23:0] == base_pixel[23:0]);
    end
  end

  // qualification by mode
  always_comb begin
    unique case (match_mode)
      MODE_ALPHA_NONZERO: qualify = (pixel_word[31:24] != 8'd0);
      MODE_ANY_NONZERO:   qualify = (pixel_word != '0);
      MODE_DIFFERS:       qualify = !same_color;
      default:            qualify = 1'b0;
    endcase
  end

  // bounds including the current pixel
  always_comb begin
    min_column_next = min_column;
    max_column_next = max_column;
    min_row_next    = min_row;
    max_row_next    = max_row;
    if (qualify) begin
      if (!any_hit || column_position < min_column) min_column_next = column_position;
      if (!any_hit || column_position > max_column) max_column_next = column_position;
      if (!any_hit || row_position < min_row)       min_row_next    = row_position;
      if (!any_hit || row_position > max_row)       max_row_next    = row_position;
    end
  end

  // only the frame's last pixel needs room in the result register
  assign in_ready = !out_valid || out_ready || !frame_end;
  assign accept   = in_valid && in_ready;

  // position and bounds state
  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
      min_column      <= '1;
      max_column      <= '0;
      min_row         <= '1;
      max_row         <= '0;
      any_hit         <= 1'b0;
    end else if (accept) begin
      if (frame_end) begin
        column_position <= '0;
        row_position    <= '0;
        min_column      <= '1;
        max_column      <= '0;
        min_row         <= '1;
        max_row         <= '0;
        any_hit         <= 1'b0;
      end else begin
        min_column <= min_column_next;
        max_column <= max_column_next;
        min_row    <= min_row_next;
        max_row    <= max_row_next;
        any_hit    <= any_hit || qualify;
        if (row_end) begin
          column_position <= '0;
          row_position    <= row_position + POS_W'(1);
        end else begin
          column_position <= column_position + POS_W'(1);
        end
      end
    end
  end

  // result word valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && frame_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (accept && frame_end) begin
      if (any_hit || qualify) begin
        found       <= 1'b1;
        rect_left   <= min_column_next;
        rect_top    <= min_row_next;
        rect_width  <= DIM_W'(max_column_next) - DIM_W'(min_column_next) + DIM_W'(1);
        rect_height <= DIM_W'(max_row_next) - DIM_W'(min_row_next) + DIM_W'(1);
      end else begin
        found       <= 1'b0;
        rect_left   <= '0;
        rect_top    <= '0;
        rect_width  <= '0;
        rect_height <= '0;
      end
    end
  end

  // a found rectangle is never empty
  assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> rect_width != '0 && rect_height != '0)
    else $error("found rectangle with zero size");

  // an empty frame reports all-zero fields
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> rect_left == '0 && rect_top == '0 &&
                            rect_width == '0 && rect_height == '0)
    else $error("empty frame with nonzero fields");

  // input stalls only behind a pending result
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready && frame_end)
    else $error("input stalled without a pending result");

  // bounds sit at their cleared values until the first hit
  assert property (@(posedge clk) disable iff (rst)
    !any_hit |-> min_column == '1 && max_column == '0 &&
                 min_row == '1 && max_row == '0)
    else $error("bounds moved without a qualifying pixel");

  // a frame-ending pixel restarts the position at the origin
  assert property (@(posedge clk) disable iff (rst)
    accept && frame_end |=> column_position == '0 && row_position == '0 && !any_hit)
    else $error("frame state not cleared after last pixel");

endmodule

`default_nettype wire
